/* hdl/fccl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_pkg
// Shared constants and types for the clamped 1-D FIR convolution block.
// ----------------------------------------------------------------------------
package fccl_pkg;

  // Number of cells in the window chain, which is also the largest mask length.
  localparam int unsigned MaxTaps = 63;

  // Field widths.
  localparam int unsigned SampleW = 8;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned HalfW   = 5;
  localparam int unsigned ProdW   = SampleW + CoefW + 1;
  localparam int unsigned AccW    = 32;

  // Largest output value.
  localparam logic [SampleW-1:0] SampleMax = 8'd255;

  // Half width after reset.
  localparam logic [HalfW-1:0] HalfWidthReset = 5'd2;

  // Controls that the sequencer sends to every cell of the chain.
  typedef struct packed {
    logic                    shift_win;
    logic                    clr_win;
    logic                    load_scan;
    logic                    step_s;
    logic                    step_c;
    logic signed [CoefW-1:0] coef_value;
  } cell_ctrl_t;

endpackage

/* hdl/fccl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_in_if
// Input channel: a coefficient load or a line sample per item.
// ----------------------------------------------------------------------------
interface fccl_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic [fccl_pkg::IndexW-1:0]            coef_index;
  logic signed [fccl_pkg::CoefW-1:0]      coef_value;
  logic [fccl_pkg::SampleW-1:0]           sample;
  logic                                   line_end;

  modport source (
    output valid, mode, coef_index, coef_value, sample, line_end,
    input  ready
  );
  modport sink (
    input  valid, mode, coef_index, coef_value, sample, line_end,
    output ready
  );
endinterface

/* hdl/fccl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_out_if
// Output channel: one smoothed sample per item.
// ----------------------------------------------------------------------------
interface fccl_out_if;
  logic                          valid;
  logic                          ready;
  logic [fccl_pkg::SampleW-1:0]  out_sample;
  logic                          out_last;

  modport source (
    output valid, out_sample, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_sample, out_last,
    output ready
  );
endinterface

/* hdl/fccl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_cell
// One cell of the chain: a window sample, a coefficient and a scan copy of
// both that moves toward the head of the chain during accumulation.
// ----------------------------------------------------------------------------
module fccl_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fccl_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                 coef_we_i,
  input  logic [fccl_pkg::SampleW-1:0]         win_prev_i,
  input  logic [fccl_pkg::SampleW-1:0]         scan_s_next_i,
  input  logic signed [fccl_pkg::CoefW-1:0]    scan_c_next_i,
  output logic [fccl_pkg::SampleW-1:0]         win_o,
  output logic [fccl_pkg::SampleW-1:0]         scan_s_o,
  output logic signed [fccl_pkg::CoefW-1:0]    scan_c_o
);

  logic [fccl_pkg::SampleW-1:0]      win_q;
  logic signed [fccl_pkg::CoefW-1:0] coef_q;
  logic [fccl_pkg::SampleW-1:0]      scan_s_q;
  logic signed [fccl_pkg::CoefW-1:0] scan_c_q;

  // Window sample: takes the neighbor's sample on each new sample, cleared at line end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.clr_win) begin
      win_q <= '0;
    end else if (ctrl_i.shift_win) begin
      win_q <= win_prev_i;
    end
  end

  // Coefficient of this mask position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (coef_we_i) begin
      coef_q <= ctrl_i.coef_value;
    end
  end

  // Scan copies: loaded from the stored values, then moved one cell per step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_scan) begin
      scan_s_q <= win_q;
      scan_c_q <= coef_q;
    end else begin
      if (ctrl_i.step_s) begin
        scan_s_q <= scan_s_next_i;
      end
      if (ctrl_i.step_c) begin
        scan_c_q <= scan_c_next_i;
      end
    end
  end

  assign win_o    = win_q;
  assign scan_s_o = scan_s_q;
  assign scan_c_o = scan_c_q;

endmodule

/* hdl/fccl_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_mac
// Multiply-accumulate at the head of the chain, with rounding and clamping
// of the accumulated Q.15 sum to an 8-bit sample.
// ----------------------------------------------------------------------------
module fccl_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clr_i,
  input  logic                                 en_i,
  input  logic [fccl_pkg::SampleW-1:0]         sample_i,
  input  logic signed [fccl_pkg::CoefW-1:0]    coef_i,
  output logic [fccl_pkg::SampleW-1:0]         result_o
);

  logic                                  prod_vld_q;
  logic signed [fccl_pkg::ProdW-1:0]     prod_q;
  logic signed [fccl_pkg::AccW-1:0]      acc_q;
  logic signed [fccl_pkg::AccW-1:0]      acc_d;
  logic [fccl_pkg::AccW-1:0]             rnd_sum;
  logic [fccl_pkg::AccW-16:0]            rnd_int;

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, sample_i}) * coef_i;
  end

  // Accumulator.
  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + fccl_pkg::AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Round half up, then clamp to the sample range.
  assign rnd_sum = $unsigned(acc_q) + fccl_pkg::AccW'(16384);
  assign rnd_int = rnd_sum[fccl_pkg::AccW-1:15];

  always_comb begin
    if (acc_q[fccl_pkg::AccW-1]) begin
      result_o = '0;
    end else if (rnd_int > (fccl_pkg::AccW-15)'(fccl_pkg::SampleMax)) begin
      result_o = fccl_pkg::SampleMax;
    end else begin
      result_o = rnd_int[fccl_pkg::SampleW-1:0];
    end
  end

endmodule

/* hdl/fir_convolution_1d_clamped_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_convolution_1d_clamped_top
// Centered 1-D convolution of a line of samples with a loadable signed mask,
// built as a chain of 63 cells feeding one multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Carries
//   -------  ---  -------------  -------------------------------------------
//   in_i     in   valid/ready    mode, coef_index, coef_value, sample, line_end
//   out_o    out  valid/ready    out_sample, out_last
//   cfg      in   cfg_we_i       half_width (cfg_data_i)
//
// A sample that gives no output passes StIdle and StDecide. Each output
// passes StDecide, StLoad, StPre (moving a scan |d - half_width| cells, d
// its lag; skipped when zero), StMac (one product per mask position that
// overlaps the line, through the cell chain into the single multiplier),
// StDrain and StEmit. A line end adds one such pass per pending output.
// Reset clears window, mask and counters. The output register holds a
// result while the sink stalls; the next item is still accepted, and the
// sequencer waits only when a new result finds that register full.

module fir_convolution_1d_clamped_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fccl_pkg::HalfW-1:0]         cfg_data_i,
  fccl_in_if.sink                            in_i,
  fccl_out_if.source                         out_o
);

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StLoad   = 3'd2;
  localparam logic [2:0] StPre    = 3'd3;
  localparam logic [2:0] StMac    = 3'd4;
  localparam logic [2:0] StDrain  = 3'd5;
  localparam logic [2:0] StEmit   = 3'd6;

  logic [2:0]                           state_q, state_d;
  logic [fccl_pkg::HalfW-1:0]           hw_q;
  logic [fccl_pkg::IndexW-1:0]          pend_q, pend_d;
  logic [fccl_pkg::IndexW-1:0]          dist_q, dist_d;
  logic [fccl_pkg::IndexW-1:0]          cnt_q, cnt_d;
  logic                                 last_q, last_d;
  logic                                 first_q, first_d;
  logic                                 neg_q, neg_d;
  logic                                 ovld_q, ovld_d;
  logic [fccl_pkg::SampleW-1:0]         osamp_q, osamp_d;
  logic                                 olast_q, olast_d;

  logic                                 in_acc;
  logic                                 out_free;
  logic                                 go;
  logic signed [fccl_pkg::IndexW:0]     off;
  logic signed [fccl_pkg::IndexW:0]     off_neg;
  logic [fccl_pkg::IndexW-1:0]          pre_len;
  logic [fccl_pkg::IndexW:0]            taps_sum;
  logic [fccl_pkg::IndexW-1:0]          taps;
  logic                                 mac_clr;
  logic                                 mac_en;
  logic [fccl_pkg::SampleW-1:0]         mac_res;

  fccl_pkg::cell_ctrl_t                 ctrl;
  logic [fccl_pkg::MaxTaps-1:0]         coef_we;
  logic [fccl_pkg::SampleW-1:0]         win   [fccl_pkg::MaxTaps];
  logic [fccl_pkg::SampleW-1:0]         scan_s[fccl_pkg::MaxTaps];
  logic signed [fccl_pkg::CoefW-1:0]    scan_c[fccl_pkg::MaxTaps];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ovld_q || out_o.ready;

  // Half width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= fccl_pkg::HalfWidthReset;
    end else if (cfg_we_i) begin
      hw_q <= cfg_data_i;
    end
  end

  // Offset of the first window position used by the mask, and the scan lengths.
  assign off      = $signed({1'b0, dist_q}) - $signed({2'b00, hw_q});
  assign off_neg  = -off;
  assign pre_len  = off[fccl_pkg::IndexW] ? off_neg[fccl_pkg::IndexW-1:0]
                                          : off[fccl_pkg::IndexW-1:0];
  assign taps_sum = {1'b0, hw_q, 1'b1} +
                    (off[fccl_pkg::IndexW] ? $unsigned(off) : '0);
  assign taps     = taps_sum[fccl_pkg::IndexW-1:0];

  // An output is due after a sample once more than half_width are pending, or every pending one at line end.
  assign go = last_q ? (pend_q != '0)
                     : (first_q && (pend_q > {1'b0, hw_q}));

  // Sequencer.
  always_comb begin
    state_d         = state_q;
    pend_d          = pend_q;
    dist_d          = dist_q;
    cnt_d           = cnt_q;
    last_d          = last_q;
    first_d         = first_q;
    neg_d           = neg_q;
    ovld_d          = ovld_q && !out_o.ready;
    osamp_d         = osamp_q;
    olast_d         = olast_q;
    ctrl.shift_win  = 1'b0;
    ctrl.clr_win    = 1'b0;
    ctrl.load_scan  = 1'b0;
    ctrl.step_s     = 1'b0;
    ctrl.step_c     = 1'b0;
    ctrl.coef_value = in_i.coef_value;
    mac_clr         = 1'b0;
    mac_en          = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc && in_i.mode) begin
          ctrl.shift_win = 1'b1;
          if (pend_q != fccl_pkg::IndexW'(fccl_pkg::MaxTaps)) begin
            pend_d = pend_q + 1'b1;
          end
          last_d  = in_i.line_end;
          first_d = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (go) begin
          dist_d  = pend_q - 1'b1;
          pend_d  = pend_q - 1'b1;
          first_d = 1'b0;
          state_d = StLoad;
        end else begin
          if (last_q) begin
            ctrl.clr_win = 1'b1;
            pend_d       = '0;
          end
          state_d = StIdle;
        end
      end
      StLoad: begin
        ctrl.load_scan = 1'b1;
        mac_clr        = 1'b1;
        neg_d          = off[fccl_pkg::IndexW];
        if (pre_len == '0) begin
          cnt_d   = taps;
          state_d = StMac;
        end else begin
          cnt_d   = pre_len;
          state_d = StPre;
        end
      end
      StPre: begin
        ctrl.step_c = neg_q;
        ctrl.step_s = !neg_q;
        if (cnt_q == 6'd1) begin
          cnt_d   = taps;
          state_d = StMac;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StMac: begin
        mac_en      = 1'b1;
        ctrl.step_s = 1'b1;
        ctrl.step_c = 1'b1;
        if (cnt_q == 6'd1) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDrain: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          osamp_d = mac_res;
          olast_d = last_q && (pend_q == '0);
          state_d = StDecide;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      first_q <= 1'b0;
      neg_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      first_q <= first_d;
      neg_q   <= neg_d;
      ovld_q  <= ovld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    osamp_q <= osamp_d;
    olast_q <= olast_d;
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = ovld_q;
  assign out_o.out_sample = osamp_q;
  assign out_o.out_last   = olast_q;

  // Cell chain: the window moves away from the head, scans move toward it.
  for (genvar j = 0; j < fccl_pkg::MaxTaps; j++) begin : g_cell
    logic [fccl_pkg::SampleW-1:0]      prev_w;
    logic [fccl_pkg::SampleW-1:0]      next_s;
    logic signed [fccl_pkg::CoefW-1:0] next_c;

    assign coef_we[j] = in_acc && !in_i.mode &&
                        (in_i.coef_index == fccl_pkg::IndexW'(j));

    if (j == 0) begin : g_head
      assign prev_w = in_i.sample;
    end else begin : g_body
      assign prev_w = win[j-1];
    end

    if (j == fccl_pkg::MaxTaps - 1) begin : g_tail
      assign next_s = '0;
      assign next_c = '0;
    end else begin : g_inner
      assign next_s = scan_s[j+1];
      assign next_c = scan_c[j+1];
    end

    fccl_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .coef_we_i     (coef_we[j]),
      .win_prev_i    (prev_w),
      .scan_s_next_i (next_s),
      .scan_c_next_i (next_c),
      .win_o         (win[j]),
      .scan_s_o      (scan_s[j]),
      .scan_c_o      (scan_c[j])
    );
  end

  // Multiply-accumulate at the head of the chain.
  fccl_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (mac_clr),
    .en_i     (mac_en),
    .sample_i (scan_s[0]),
    .coef_i   (scan_c[0]),
    .result_o (mac_res)
  );

endmodule

/* sim/fccl_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_tb_pkg
// Item codes and the input item layout shared by the stimulus and the
// checker of the clamped 1-D FIR convolution testbench.
// ----------------------------------------------------------------------------
package fccl_tb_pkg;

  // What an input item carries.
  typedef enum logic {
    ModeCoef   = 1'b0,
    ModeSample = 1'b1
  } item_mode_e;

  // One item on the input channel.
  typedef struct packed {
    item_mode_e                               mode;
    logic [fccl_pkg::IndexW-1:0]              coef_index;
    logic signed [fccl_pkg::CoefW-1:0]        coef_value;
    logic [fccl_pkg::SampleW-1:0]             sample;
    logic                                     line_end;
  } stim_item_t;

endpackage

/* sim/fccl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccl_checker
// Watches both channels and the half width port, predicts every smoothed
// sample from its own copy of window, mask and backlog, and compares each
// output item in order against the predicted one.
// ----------------------------------------------------------------------------
module fccl_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fccl_pkg::HalfW-1:0] cfg_data_i,
  fccl_in_if                         in_i,
  fccl_out_if                        res_i,
  output int unsigned                outstanding_o,
  output int unsigned                checked_o,
  output int unsigned                fail_count_o
);
  import fccl_pkg::*;
  import fccl_tb_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } smoothed_t;

  // Predicted block state.
  logic [SampleW-1:0]      window_q [MaxTaps];
  logic signed [CoefW-1:0] mask_q   [MaxTaps];
  logic [HalfW-1:0]        half_width_q;
  int unsigned             backlog_q;
  smoothed_t               smoothed_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count_o++;
  endtask

  // Smoothed value centered lag places before the newest sample.
  function automatic logic [SampleW-1:0] smooth_at(input int lag);
    longint acc;
    int     hw;
    int     pos;
    int     tap;
    acc = 0;
    hw  = int'(half_width_q);
    for (int i = -hw; i <= hw; i++) begin
      pos = lag + i;
      tap = i + hw;
      if (pos < 0 || pos >= int'(MaxTaps) || tap >= int'(MaxTaps)) continue;
      acc += longint'(mask_q[tap]) * longint'({1'b0, window_q[pos]});
    end
    if (acc < 0) return '0;
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 255) return SampleMax;
    return acc[SampleW-1:0];
  endfunction

  // A sample shifts the window and may release outputs; a line end flushes.
  task automatic take_sample(input logic [SampleW-1:0] smp, input logic line_end);
    smoothed_t res;
    for (int k = MaxTaps - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = smp;
    if (backlog_q < MaxTaps) backlog_q++;
    if (backlog_q > half_width_q) begin
      backlog_q--;
      res.value = smooth_at(backlog_q);
      res.last  = line_end && (backlog_q == 0);
      smoothed_q.push_back(res);
    end
    if (line_end) begin
      while (backlog_q > 0) begin
        backlog_q--;
        res.value = smooth_at(backlog_q);
        res.last  = (backlog_q == 0);
        smoothed_q.push_back(res);
      end
      foreach (window_q[k]) window_q[k] = '0;
    end
  endtask

  task automatic check_result();
    smoothed_t want;
    if (smoothed_q.size() == 0) begin
      report_mismatch($sformatf("output item %0d (last %0b) with nothing expected",
                                res_i.out_sample, res_i.out_last));
    end else begin
      want = smoothed_q.pop_front();
      checked_o++;
      if (res_i.out_sample !== want.value)
        report_mismatch($sformatf("out_sample expected %0d, got %0d",
                                  want.value, res_i.out_sample));
      if (res_i.out_last !== want.last)
        report_mismatch($sformatf("out_last expected %0b, got %0b",
                                  want.last, res_i.out_last));
    end
  endtask

  // Outputs are compared before new input is predicted; no result can leave
  // the block in the cycle its sample enters.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (window_q[k]) window_q[k] = '0;
      foreach (mask_q[k]) mask_q[k] = '0;
      half_width_q = HalfWidthReset;
      backlog_q    = 0;
      smoothed_q.delete();
      checked_o    = 0;
      fail_count_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (cfg_we_i) half_width_q = cfg_data_i;
      if (in_i.valid && in_i.ready) begin
        if (in_i.mode == ModeCoef) begin
          if (in_i.coef_index < MaxTaps) mask_q[in_i.coef_index] = in_i.coef_value;
        end else begin
          take_sample(in_i.sample, in_i.line_end);
        end
      end
    end
    outstanding_o = smoothed_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives mask loads and sample lines into the clamped 1-D FIR convolution
// block under random source and sink stalls, across half widths from 0 to 31,
// with half width changes inside open lines, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fccl_pkg::*;
  import fccl_tb_pkg::*;

  localparam int unsigned SettleCycles = 200;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned NumPhases    = 9;

  typedef enum logic [1:0] {
    MaskSmooth,
    MaskSigned,
    MaskRandom,
    MaskPatch
  } mask_style_e;

  typedef struct {
    int unsigned half_width;
    int unsigned samples;
    bit          open_line;
    mask_style_e style;
  } phase_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [HalfW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned n_loads;
  int unsigned n_samples;
  int unsigned n_lines;

  fccl_in_if  in_ch ();
  fccl_out_if out_ch ();

  fir_convolution_1d_clamped_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  fccl_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .in_i          (in_ch),
    .res_i         (out_ch),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sink stalls at random.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, StallLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Coefficient load; sample and line_end are noise the block ignores.
  function automatic stim_item_t coef_item(input int unsigned idx,
                                           input logic [CoefW-1:0] value);
    stim_item_t it;
    it.mode       = ModeCoef;
    it.coef_index = idx[IndexW-1:0];
    it.coef_value = value;
    it.sample     = 8'($urandom);
    it.line_end   = 1'($urandom);
    return it;
  endfunction

  function automatic stim_item_t sample_item(input logic [SampleW-1:0] value,
                                             input logic last);
    stim_item_t it;
    it.mode       = ModeSample;
    it.coef_index = 6'($urandom);
    it.coef_value = 16'($urandom);
    it.sample     = value;
    it.line_end   = last;
    return it;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? SampleMax : '0;
    return 8'($urandom);
  endfunction

  function automatic int unsigned line_length(input int unsigned hw);
    if ($urandom_range(5) == 0) return $urandom_range(hw + 1, 2 * hw + 8);
    return $urandom_range(1, hw + 3);
  endfunction

  // Smooth masks sum to about unity so outputs stay mostly inside 0..255.
  function automatic logic [CoefW-1:0] mask_coef(input mask_style_e style,
                                                 input int unsigned taps);
    int share;
    int v;
    share = 32768 / taps;
    case (style)
      MaskSmooth: v = $urandom_range(0, 2 * share);
      MaskSigned: v = int'($urandom_range(0, 4 * share)) - share;
      default:    v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CoefW'(v);
  endfunction

  task automatic send_item(input stim_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= it.mode;
    in_ch.coef_index <= it.coef_index;
    in_ch.coef_value <= it.coef_value;
    in_ch.sample     <= it.sample;
    in_ch.line_end   <= it.line_end;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    if (it.mode == ModeCoef) begin
      n_loads++;
    end else begin
      n_samples++;
      if (it.line_end) n_lines++;
    end
  endtask

  // Hold off until every predicted output is out, then let the block settle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One phase: new half width, a mask, then lines of random samples.
  task automatic run_phase(input phase_t ph);
    int unsigned taps;
    int unsigned remaining;
    int unsigned len;
    drain_block();
    cfg_we   <= 1'b1;
    cfg_data <= ph.half_width[HalfW-1:0];
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    taps = 2 * ph.half_width + 1;
    if (ph.style == MaskPatch) begin
      repeat (6) send_item(coef_item($urandom_range(0, taps - 1), mask_coef(MaskSmooth, taps)));
    end else begin
      for (int t = 0; t < taps; t++) send_item(coef_item(t, mask_coef(ph.style, taps)));
    end
    remaining = ph.samples;
    while (remaining > 0) begin
      len = ph.open_line ? remaining : line_length(ph.half_width);
      if (len > remaining) len = remaining;
      for (int j = 0; j < len; j++) begin
        // Occasional stray load in the middle of a line.
        if ($urandom_range(11) == 0)
          send_item(coef_item($urandom_range(0, 63), 16'($urandom)));
        send_item(sample_item(pick_sample(), (j == len - 1) && !ph.open_line));
      end
      remaining -= len;
    end
  endtask

  initial begin
    phase_t     plan [NumPhases];
    stim_item_t it;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = ModeCoef;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.sample     = '0;
    in_ch.line_end   = 1'b0;
    out_ch.ready     = 1'b0;
    quiet_cycles     = 0;
    n_loads          = 0;
    n_samples        = 0;
    n_lines          = 0;
    src_idle_pct     = 11;
    snk_idle_pct     = 53;

    // Open lines carry over into the next phase, so the half width changes
    // while samples are still pending.
    plan[0] = '{1, 24, 1'b0, MaskSmooth};
    plan[1] = '{0, 24, 1'b0, MaskSigned};
    plan[2] = '{31, 36, 1'b1, MaskSmooth};
    plan[3] = '{3, 24, 1'b0, MaskPatch};
    plan[4] = '{1, 10, 1'b1, MaskSigned};
    plan[5] = '{20, 30, 1'b0, MaskPatch};
    plan[6] = '{$urandom_range(0, 31), 28, 1'b0, MaskRandom};
    plan[7] = '{31, 24, 1'b0, MaskPatch};
    plan[8] = '{$urandom_range(0, 15), 30, 1'b0, MaskSmooth};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset half width of two.
    it = coef_item(0, 16'd4096);
    it.sample   = SampleMax;
    it.line_end = 1'b1;
    send_item(it);
    send_item(coef_item(1, 16'd8192));
    send_item(coef_item(2, 16'd8192));
    send_item(coef_item(3, 16'd8192));
    send_item(coef_item(4, 16'd4096));
    send_item(coef_item(62, 16'h7FFF));
    send_item(coef_item(61, 16'h8000));
    // Index past the mask store is dropped.
    send_item(coef_item(63, 16'hFFFF));
    send_item(sample_item(8'd255, 1'b0));
    send_item(sample_item(8'd0, 1'b0));
    send_item(sample_item(8'd255, 1'b0));
    send_item(sample_item(8'd128, 1'b0));
    send_item(sample_item(8'd1, 1'b1));
    // A line of one sample, then a line as long as the half width.
    send_item(sample_item(8'd200, 1'b1));
    send_item(sample_item(8'd255, 1'b0));
    send_item(sample_item(8'd17, 1'b1));
    // Extreme center taps drive the output into both clamps.
    send_item(coef_item(2, 16'h7FFF));
    send_item(coef_item(1, 16'h8000));
    send_item(sample_item(8'd255, 1'b0));
    send_item(sample_item(8'd255, 1'b0));
    send_item(sample_item(8'd0, 1'b0));
    send_item(sample_item(8'd255, 1'b1));

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        src_idle_pct = 53;
        snk_idle_pct = 11;
      end
      if (p == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      run_phase(plan[p]);
    end
    drain_block();

    $display("Sent %0d samples in %0d lines and %0d mask loads; %0d outputs compared.",
             n_samples, n_lines, n_loads, checked);
    $display("Half widths 0 to 31 were run, some changed while a line was still open.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* fir_convolution_1d_clamped_top.f */
hdl/fccl_pkg.sv
hdl/fccl_in_if.sv
hdl/fccl_out_if.sv
hdl/fccl_cell.sv
hdl/fccl_mac.sv
hdl/fir_convolution_1d_clamped_top.sv
sim/fccl_tb_pkg.sv
sim/fccl_checker.sv
sim/testbench.sv
